>>> rtl/pale_pkg.sv
// shared constants, codes and cell control types for the positional array list engine
package pale_pkg;

  // list storage geometry
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // item field widths
  localparam int OP_W   = 3;
  localparam int POS_W  = 5;
  localparam int DATA_W = 32;
  localparam int ST_W   = 2;
  localparam int FIDX_W = 4;
  localparam int FCNT_W = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OP_W-1:0] OP_READ   = 3'd2;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
  localparam logic [ST_W-1:0] ST_REJECT = 2'd1;
  localparam logic [ST_W-1:0] ST_MISS   = 2'd2;

  // cell data source select
  typedef enum logic [1:0] {
    SEL_KEEP,
    SEL_LEFT,
    SEL_RIGHT,
    SEL_LOAD
  } cell_sel_t;

  // per-cell control: enable and data source select
  typedef struct packed {
    logic      en;
    cell_sel_t sel;
  } cell_ctl_t;

endpackage

>>> rtl/pale_if.sv
// request and response channel interfaces of the positional array list engine
interface pale_req_if
  import pale_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, operation, position, value, input ready);
  modport sink (input valid, operation, position, value, output ready);
endinterface

interface pale_rsp_if
  import pale_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [ST_W-1:0]          status;
  logic signed [DATA_W-1:0] read_value;
  logic [FIDX_W-1:0]        found_index;
  logic [FCNT_W-1:0]        entry_count;

  modport source (output valid, status, read_value, found_index, entry_count, input ready);
  modport sink (input valid, status, read_value, found_index, entry_count, output ready);
endinterface

>>> rtl/pale_cell.sv
// one list cell: holds an entry, shifts with its neighbors and compares against a key
module pale_cell
  import pale_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  input  logic [DATA_W-1:0] key,
  output logic [DATA_W-1:0] data,
  output logic              match
);

  logic [DATA_W-1:0] data_next;

  // pick the source for the stored entry
  always_comb begin
    case (ctl.sel)
      SEL_LEFT:  data_next = left_data;
      SEL_RIGHT: data_next = right_data;
      SEL_LOAD:  data_next = key;
      default:   data_next = data;
    endcase
  end

  // entry and compare flag update on a transfer
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      data  <= data_next;
      match <= (data == key);
    end
  end

endmodule

>>> rtl/positional_array_list_engine.sv
// top level: cell chain, list count, result stage and response register
//
// Ordered list of up to DEPTH signed 32-bit entries held in a chain of cells.
// Requests arrive on req (operation, position, value) and responses leave on
// rsp (status, read_value, found_index, entry_count), both valid/ready; a
// transfer happens when valid and ready are high at a rising clock edge.
// Every request gives exactly one response.
// At the request transfer all cells shift or load together (insert moves
// entries up, remove moves them down) and every cell compares its entry with
// the request value. The result stage then resolves the lowest matching cell
// and writes the response register once that register is free. A new request
// is taken once the previous one has reached the response register.
// If the receiver stalls, the response register holds its item; one more
// request can be taken and waits in the result stage, after which req.ready
// stays low until the response register drains.
// Synchronous reset empties the list (count zero) and drops any pending
// result; the cell contents are left as they are and are never read before
// being written.
module positional_array_list_engine
  import pale_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  pale_req_if.sink   req,
  pale_rsp_if.source rsp
);

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              req_xfer;
  logic [POS_W-1:0]  pos;
  logic [CNT_W+POS_W-1:0] pos_cmp;
  logic              ins_ok;
  logic              pos_ok;
  logic [ST_W-1:0]   status_next;
  logic [DATA_W-1:0] read_next;

  logic [DATA_W-1:0] cell_data  [DEPTH];
  logic              cell_match [DEPTH];
  cell_ctl_t         cell_ctl   [DEPTH];
  logic [DEPTH-1:0]  hit;

  // result stage
  logic              pending;
  logic [OP_W-1:0]   s_op;
  logic [ST_W-1:0]   s_status;
  logic [DATA_W-1:0] s_read;
  logic [CNT_W-1:0]  s_count;
  logic [CNT_W-1:0]  s_range;

  // response register
  logic              rsp_valid;
  logic [ST_W-1:0]   rsp_status;
  logic [DATA_W-1:0] rsp_read;
  logic [FIDX_W-1:0] rsp_index;
  logic [FCNT_W-1:0] rsp_count;
  logic              rsp_load;
  logic              any_hit;
  logic [FIDX_W-1:0] hit_index;

  assign req.ready = !pending;
  assign req_xfer  = req.valid && req.ready;
  assign pos       = req.position;

  // position checks against the current count
  assign pos_cmp = {{POS_W{1'b0}}, count};
  assign ins_ok  = (count < CNT_W'(DEPTH)) && ({{CNT_W{1'b0}}, pos} <= pos_cmp);
  assign pos_ok  = {{CNT_W{1'b0}}, pos} < pos_cmp;

  // status, read data and new count for the request
  always_comb begin
    status_next = ST_DONE;
    read_next   = '0;
    count_next  = count;
    unique case (req.operation)
      OP_INSERT: begin
        if (ins_ok) count_next = count + CNT_W'(1);
        else        status_next = ST_REJECT;
      end
      OP_REMOVE: begin
        if (pos_ok) count_next = count - CNT_W'(1);
        else        status_next = ST_REJECT;
      end
      OP_READ: begin
        if (pos_ok) read_next = cell_data[pos[IDX_W-1:0]];
        else        status_next = ST_REJECT;
      end
      OP_FIND:  status_next = ST_MISS;
      OP_CLEAR: count_next = '0;
      default:  status_next = ST_REJECT;
    endcase
  end

  // cell chain with per-cell shift control
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [POS_W-1:0] CELL_POS = POS_W'(i);
    logic [DATA_W-1:0] left_data;
    logic [DATA_W-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = cell_data[i];
    end else begin : g_mid
      assign left_data = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_inner
      assign right_data = cell_data[i+1];
    end

    always_comb begin
      cell_ctl[i].en  = req_xfer;
      cell_ctl[i].sel = SEL_KEEP;
      if (req.operation == OP_INSERT && ins_ok) begin
        if (CELL_POS > pos)       cell_ctl[i].sel = SEL_LEFT;
        else if (CELL_POS == pos) cell_ctl[i].sel = SEL_LOAD;
      end else if (req.operation == OP_REMOVE && pos_ok) begin
        if (CELL_POS >= pos) cell_ctl[i].sel = SEL_RIGHT;
      end
    end

    pale_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[i]),
      .left_data  (left_data),
      .right_data (right_data),
      .key        (req.value),
      .data       (cell_data[i]),
      .match      (cell_match[i])
    );

    // only cells below the count at the time of the find take part
    assign hit[i] = cell_match[i] && (CNT_W'(i) < s_range);
  end

  // lowest matching cell
  always_comb begin
    any_hit   = |hit;
    hit_index = '0;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if (hit[k]) hit_index = FIDX_W'(k);
    end
  end

  // list count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (req_xfer) begin
      count <= count_next;
    end
  end

  // result stage capture
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      s_op     <= req.operation;
      s_status <= status_next;
      s_read   <= read_next;
      s_count  <= count_next;
      s_range  <= count;
    end
  end

  assign rsp_load = pending && (!rsp_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (req_xfer) begin
      pending <= 1'b1;
    end else if (rsp_load) begin
      pending <= 1'b0;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_read  <= s_read;
      rsp_count <= FCNT_W'(s_count);
      if (s_op == OP_FIND && any_hit) begin
        rsp_status <= ST_DONE;
        rsp_index  <= hit_index;
      end else begin
        rsp_status <= s_status;
        rsp_index  <= '0;
      end
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.read_value  = rsp_read;
  assign rsp.found_index = rsp_index;
  assign rsp.entry_count = rsp_count;

  // count never passes the list depth
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("list count above depth");

  // a request transfer always leaves a pending result
  assert property (@(posedge clk) disable iff (rst) req_xfer |=> pending)
    else $error("request transfer lost");

  // a pending result moves to a free response register in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (pending && !rsp_valid) |=> (!pending && rsp_valid))
    else $error("pending result not forwarded");

  // a find reports done only when a hit was seen
  assert property (@(posedge clk) disable iff (rst)
    (rsp_load && s_op == OP_FIND && !any_hit) |=> (rsp_status == ST_MISS))
    else $error("find without hit not reported as miss");

endmodule

>>> dv/pale_list_checker.sv
// checker for the positional array list engine: list model, response queue and compare
module pale_list_checker
  import pale_pkg::*;
(
  input  logic clk,
  input  logic rst,
  pale_req_if  req,
  pale_rsp_if  rsp,
  output int   mismatches,
  output int   waiting
);

  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] read_value;
    logic [FIDX_W-1:0]        found_index;
    logic [FCNT_W-1:0]        entry_count;
  } list_rsp_t;

  // model of the list contents and length
  logic signed [DATA_W-1:0] list_mem [DEPTH];
  int                       list_len;
  list_rsp_t                rsp_due [$];

  initial begin
    mismatches = 0;
    waiting    = 0;
    list_len   = 0;
  end

  // apply one operation to the list model and build its response
  function automatic list_rsp_t apply_list_op(input logic [OP_W-1:0] op,
                                              input logic [POS_W-1:0] pos,
                                              input logic signed [DATA_W-1:0] val);
    list_rsp_t r;
    int        p;
    bit        hit;
    r   = '0;
    p   = int'(pos);
    hit = 1'b0;
    case (op)
      OP_INSERT: begin
        if (list_len >= DEPTH || p > list_len) begin
          r.status = ST_REJECT;
        end else begin
          for (int i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p] = val;
          list_len++;
        end
      end
      OP_REMOVE: begin
        if (list_len == 0 || p >= list_len) begin
          r.status = ST_REJECT;
        end else begin
          for (int i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      OP_READ: begin
        if (p >= list_len) r.status = ST_REJECT;
        else r.read_value = list_mem[p];
      end
      OP_FIND: begin
        r.status = ST_MISS;
        // lowest matching index wins
        for (int i = 0; i < list_len; i++) begin
          if (!hit && list_mem[i] == val) begin
            hit           = 1'b1;
            r.status      = ST_DONE;
            r.found_index = i[FIDX_W-1:0];
          end
        end
      end
      OP_CLEAR: begin
        list_len = 0;
      end
      default: begin
        r.status = ST_REJECT;
      end
    endcase
    r.entry_count = list_len[FCNT_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // compare response transfers, then queue the prediction for a request transfer
  always @(posedge clk) begin
    list_rsp_t want;
    if (rst) begin
      rsp_due.delete();
      list_len = 0;
      waiting <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (rsp_due.size() == 0) begin
          $error("response transfer with no request outstanding");
          mismatches++;
        end else begin
          want = rsp_due.pop_front();
          check_field("status", DATA_W'(want.status), DATA_W'(rsp.status));
          check_field("read_value", want.read_value, rsp.read_value);
          check_field("found_index", DATA_W'(want.found_index), DATA_W'(rsp.found_index));
          check_field("entry_count", DATA_W'(want.entry_count), DATA_W'(rsp.entry_count));
        end
      end
      if (req.valid && req.ready)
        rsp_due.push_back(apply_list_op(req.operation, req.position, req.value));
      waiting <= rsp_due.size();
    end
  end

endmodule

>>> dv/tb_positional_array_list_engine.sv
// testbench top for the positional array list engine: clock, reset, stimulus and verdict
module tb_positional_array_list_engine;
  import pale_pkg::*;

  localparam int RAND_ITEMS  = 850;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic signed [DATA_W-1:0] V_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] V_MAX = 32'sh7fff_ffff;

  logic clk;
  logic rst = 1'b1;
  logic sink_ready = 1'b0;
  bit   calm = 1'b0;
  int   hold = 0;
  int   cycles = 0;
  int   mismatches;
  int   waiting;
  int   fill = 0;
  logic signed [DATA_W-1:0] pool [8];

  pale_req_if req_ch ();
  pale_rsp_if rsp_ch ();

  assign rsp_ch.ready = sink_ready;

  positional_array_list_engine u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  pale_list_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .mismatches (mismatches),
    .waiting    (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[positional_array_list_engine] ERROR");
      $finish;
    end
  end

  // response side: random stall after each transfer, none in calm phases
  always @(posedge clk) begin
    int gap;
    if (rst) begin
      sink_ready <= 1'b0;
      hold       <= 0;
    end else if (hold > 0) begin
      hold <= hold - 1;
    end else if (rsp_ch.valid && sink_ready) begin
      gap = calm ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        sink_ready <= 1'b0;
        hold       <= gap - 1;
      end else begin
        sink_ready <= 1'b1;
      end
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // one request transfer after a random gap (none in calm phases); fill tracks the list length for shaping
  task automatic send_req(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                          input logic signed [DATA_W-1:0] val);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.position  <= pos;
    req_ch.value     <= val;
    do @(posedge clk); while (!req_ch.ready);
    case (op)
      OP_INSERT: if (fill < DEPTH && int'(pos) <= fill) fill++;
      OP_REMOVE: if (fill > 0 && int'(pos) < fill) fill--;
      OP_CLEAR:  fill = 0;
      default: ;
    endcase
  endtask

  // hold off the sender until every response has come back
  task automatic drain_wait();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
  endtask

  initial begin
    int ins_w, rem_w, mode, roll;
    logic [OP_W-1:0]          op;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    req_ch.valid     <= 1'b0;
    req_ch.operation <= OP_INSERT;
    req_ch.position  <= '0;
    req_ch.value     <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty list corners
    send_req(OP_CLEAR, 5'd0, 32'sd0);
    send_req(OP_READ, 5'd0, 32'sd0);
    send_req(OP_REMOVE, 5'd0, 32'sd0);
    send_req(OP_INSERT, 5'd1, 32'sd7);
    send_req(OP_FIND, 5'd0, 32'sd5);
    // directed: small list, extremes of value
    send_req(OP_INSERT, 5'd0, V_MAX);
    send_req(OP_INSERT, 5'd0, V_MIN);
    send_req(OP_INSERT, 5'd2, -32'sd1);
    send_req(OP_FIND, 5'd0, V_MAX);
    send_req(OP_FIND, 5'd0, 32'sd0);
    send_req(OP_READ, 5'd2, 32'sd0);
    send_req(OP_READ, 5'd3, 32'sd0);
    send_req(OP_REMOVE, 5'd1, 32'sd0);
    send_req(OP_REMOVE, 5'd2, 32'sd0);
    send_req(3'd7, 5'd31, -32'sd1);
    // directed: fill to capacity, then full and top-index corners
    while (fill < DEPTH) send_req(OP_INSERT, POS_W'(fill), 32'sd1000 + fill);
    send_req(OP_INSERT, 5'd16, 32'sd3);
    send_req(OP_READ, 5'd15, 32'sd0);
    send_req(OP_FIND, 5'd0, 32'sd1015);
    send_req(OP_REMOVE, 5'd15, 32'sd0);
    send_req(OP_REMOVE, 5'd31, 32'sd0);
    send_req(OP_CLEAR, 5'd31, V_MIN);
    send_req(OP_READ, 5'd0, 32'sd0);

    // random phases: fill-heavy, drain-heavy and mixed
    mode  = 0;
    ins_w = 35;
    rem_w = 20;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 100 == 0) begin
        mode = $urandom_range(0, 2);
        calm = ($urandom_range(0, 3) == 0);
        ins_w = (mode == 0) ? 55 : (mode == 1) ? 20 : 35;
        rem_w = (mode == 0) ? 10 : (mode == 1) ? 35 : 20;
        pool[0] = 32'sd0;
        for (int k = 1; k < 8; k++) pool[k] = $urandom;
      end
      if (n == RAND_ITEMS / 2) drain_wait();
      roll = $urandom_range(0, 99);
      if (roll < ins_w) op = OP_INSERT;
      else if (roll < ins_w + rem_w) op = OP_REMOVE;
      else if (roll < ins_w + rem_w + 20) op = OP_READ;
      else if (roll < 95) op = OP_FIND;
      else if (roll < 97) op = OP_CLEAR;
      else op = OP_W'($urandom_range(int'(OP_CLEAR) + 1, 7));
      // mostly legal positions, sometimes anything the field holds
      if ($urandom_range(0, 99) < 85) begin
        if (op == OP_INSERT) pos = POS_W'($urandom_range(0, fill));
        else pos = (fill > 0) ? POS_W'($urandom_range(0, fill - 1)) : '0;
      end else begin
        pos = POS_W'($urandom_range(0, 31));
      end
      roll = $urandom_range(0, 99);
      if (roll < 50) val = pool[$urandom_range(0, 7)];
      else if (roll < 55) val = roll[0] ? V_MAX : V_MIN;
      else val = $urandom;
      send_req(op, pos, val);
    end

    drain_wait();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[positional_array_list_engine] OK");
    end else begin
      $display("[positional_array_list_engine] ERROR");
    end
    $finish;
  end

endmodule
